### rtl/wtsac_pkg.sv
// shared types and constants for the write-through set-associative cache
// no dependencies; imported by every module of the block
package wtsac_pkg;

   localparam int ADDR_W = 16;
   localparam int WORD_W = 16;

   // default sizes, handed down from the top level
   localparam int DEF_MEM_WORDS      = 32768;
   localparam int DEF_TOTAL_LINES    = 16;
   localparam int DEF_WORDS_PER_LINE = 4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INVAL = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // cache_mode codes, anything else means bypass
   localparam logic [1:0] MODE_BYPASS  = 2'd0;
   localparam logic [1:0] MODE_DIRECT  = 2'd1;
   localparam logic [1:0] MODE_TWO_WAY = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LOOKUP,
      ST_DATA_RD,
      ST_MEM_RD,
      ST_FILL,
      ST_FILL_END,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic two_way;
      logic alloc;
      logic touch;
      logic inval;
   } tag_cmd_type;

   typedef struct packed {
      logic hit;
      logic hit_way;
   } tag_stat_type;

endpackage

### rtl/wtsac_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// depends on wtsac_pkg
module wtsac_ram import wtsac_pkg::*; #(
   parameter int DEPTH     = DEF_TOTAL_LINES,
   parameter int WIDTH     = WORD_W,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] storage [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         storage[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wtsac_tag_store.sv
// tag banks, valid bits and lru bits with the hit and victim logic
// depends on wtsac_pkg and wtsac_ram
module wtsac_tag_store import wtsac_pkg::*; #(
   parameter int TOTAL_LINES    = DEF_TOTAL_LINES,
   parameter int WORDS_PER_LINE = DEF_WORDS_PER_LINE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ADDR_W-1:0]              addr,
   input  tag_cmd_type                    cmd,
   output tag_stat_type                   stat,
   output logic [$clog2(TOTAL_LINES)-1:0] line
);

   localparam int OFF_W = $clog2(WORDS_PER_LINE);
   localparam int LINE_W = $clog2(TOTAL_LINES);
   localparam int ROWS = TOTAL_LINES / 2;
   localparam int ROW_W = (LINE_W > 1) ? LINE_W - 1 : 1;
   localparam int TAG_W = ADDR_W - OFF_W - LINE_W + 1;
   localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'(ROWS - 1);

   logic [ADDR_W-1:0]      blk;
   logic [ROW_W-1:0]       row;
   logic [TAG_W-1:0]       tag;
   logic                   dir_way;
   logic [LINE_W-1:0]      line0;
   logic [LINE_W-1:0]      line1;
   logic [TAG_W-1:0]       tag0_rd;
   logic [TAG_W-1:0]       tag1_rd;
   logic                   hit0;
   logic                   hit1;
   logic                   victim;
   logic                   sel_way;
   logic [TOTAL_LINES-1:0] valid_ff;
   logic [TOTAL_LINES-1:0] valid_in;
   logic [TOTAL_LINES-1:0] lru_ff;
   logic [TOTAL_LINES-1:0] lru_in;

   // address split: two-way uses half as many sets with one more tag bit
   always_comb begin
      blk = addr >> OFF_W;
      dir_way = blk[0];
      if (cmd.two_way) begin
         row = blk[ROW_W-1:0] & ROW_MASK;
         tag = TAG_W'(blk >> (LINE_W - 1));
      end else begin
         row = blk[ROW_W:1] & ROW_MASK;
         tag = TAG_W'(blk >> LINE_W);
      end
      line0 = LINE_W'({row, 1'b0});
      line1 = LINE_W'({row, 1'b1});
   end

   wtsac_ram #(.DEPTH(ROWS), .WIDTH(TAG_W)) u_tag_bank0 (
      .clock   (clock),
      .we      (cmd.alloc && !victim),
      .wr_addr (row),
      .wr_data (tag),
      .rd_addr (row),
      .rd_data (tag0_rd)
   );

   wtsac_ram #(.DEPTH(ROWS), .WIDTH(TAG_W)) u_tag_bank1 (
      .clock   (clock),
      .we      (cmd.alloc && victim),
      .wr_addr (row),
      .wr_data (tag),
      .rd_addr (row),
      .rd_data (tag1_rd)
   );

   // direct mapped looks at one way only
   always_comb begin
      hit0 = valid_ff[line0] && (tag0_rd == tag) && (cmd.two_way || !dir_way);
      hit1 = valid_ff[line1] && (tag1_rd == tag) && (cmd.two_way || dir_way);
      stat.hit = hit0 || hit1;
      stat.hit_way = !hit0;
      victim = cmd.two_way ? !lru_ff[line0] : dir_way;
      sel_way = stat.hit ? stat.hit_way : victim;
      line = sel_way ? line1 : line0;
   end

   always_comb begin
      valid_in = valid_ff;
      lru_in = lru_ff;
      if (cmd.inval) begin
         valid_in = '0;
      end else if (cmd.alloc) begin
         valid_in[line] = 1'b1;
      end
      if (cmd.touch && cmd.two_way) begin
         lru_in[line0] = sel_way;
         lru_in[line1] = !sel_way;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         lru_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         lru_ff <= lru_in;
      end
   end

endmodule

### rtl/wtsac_ctrl.sv
// sequencer: request decode, lookup, line fill, memory clear and response register
// depends on wtsac_pkg; drives the tag store and both rams
module wtsac_ctrl import wtsac_pkg::*; #(
   parameter int MEM_WORDS      = DEF_MEM_WORDS,
   parameter int TOTAL_LINES    = DEF_TOTAL_LINES,
   parameter int WORDS_PER_LINE = DEF_WORDS_PER_LINE
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [2*WORD_W-1:0]                           req_tdata,
   input  logic [1:0]                                    req_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [WORD_W-1:0]                             rsp_tdata,
   output logic [1:0]                                    rsp_tuser,
   input  logic [1:0]                                    cache_mode,
   output logic [ADDR_W-1:0]                             req_addr,
   output tag_cmd_type                                   tag_cmd,
   input  tag_stat_type                                  tag_stat,
   input  logic [$clog2(TOTAL_LINES)-1:0]                cur_line,
   output logic [$clog2(MEM_WORDS)-1:0]                  bk_rd_addr,
   input  logic [WORD_W-1:0]                             bk_rd_data,
   output logic                                          bk_we,
   output logic [$clog2(MEM_WORDS)-1:0]                  bk_wr_addr,
   output logic [WORD_W-1:0]                             bk_wr_data,
   output logic [$clog2(TOTAL_LINES*WORDS_PER_LINE)-1:0] dt_rd_addr,
   input  logic [WORD_W-1:0]                             dt_rd_data,
   output logic                                          dt_we,
   output logic [$clog2(TOTAL_LINES*WORDS_PER_LINE)-1:0] dt_wr_addr,
   output logic [WORD_W-1:0]                             dt_wr_data
);

   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int LINE_W = $clog2(TOTAL_LINES);
   localparam int DATA_AW = $clog2(TOTAL_LINES * WORDS_PER_LINE);
   localparam int OFF_W = $clog2(WORDS_PER_LINE);
   localparam int OFF_IW = (OFF_W > 0) ? OFF_W : 1;
   localparam logic [OFF_IW-1:0] OFF_MASK = OFF_IW'(WORDS_PER_LINE - 1);
   localparam logic [OFF_IW-1:0] FILL_LAST = OFF_IW'(WORDS_PER_LINE - 1);
   localparam logic [ADDR_W-1:0] START_MASK = ~ADDR_W'(WORDS_PER_LINE - 1);
   localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_WORDS);
   localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] wdata_ff, wdata_in;
   logic [WORD_W-1:0] res_data_ff, res_data_in;
   logic res_hit_ff, res_hit_in;
   logic res_err_ff, res_err_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [OFF_IW-1:0] fill_idx_ff, fill_idx_in;
   logic pipe_vld_ff, pipe_vld_in;
   logic [OFF_IW-1:0] pipe_idx_ff, pipe_idx_in;
   logic pipe_zero_ff, pipe_zero_in;
   logic [MEM_AW-1:0] clr_idx_ff, clr_idx_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_err_ff, rsp_err_in;

   logic cache_on;
   logic range_bad;
   logic rsp_free;
   logic [OFF_IW-1:0] off;
   logic [ADDR_W:0] fill_addr;
   logic [WORD_W-1:0] fill_word;
   logic is_rw;

   function automatic logic [DATA_AW-1:0] data_addr(input logic [LINE_W-1:0] ln,
                                                   input logic [OFF_IW-1:0] idx);
      data_addr = (DATA_AW'(ln) << OFF_W) | DATA_AW'(idx);
   endfunction

   always_comb begin
      cache_on = (cache_mode == MODE_DIRECT) || (cache_mode == MODE_TWO_WAY);
      is_rw = (op_ff == OP_READ) || (op_ff == OP_WRITE);
      range_bad = {1'b0, addr_ff} >= MEM_LIMIT;
      rsp_free = !rsp_valid_ff || rsp_tready;
      off = addr_ff[OFF_IW-1:0] & OFF_MASK;
      fill_addr = (ADDR_W + 1)'(addr_ff & START_MASK) + (ADDR_W + 1)'(fill_idx_ff);
      fill_word = pipe_zero_ff ? '0 : bk_rd_data;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == CLR_LAST) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (op_ff)
               OP_INVAL: state_in = ST_RESP;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ, OP_WRITE: begin
                  priority if (range_bad) state_in = ST_RESP;
                  else if (cache_on) state_in = ST_LOOKUP;
                  else if (op_ff == OP_READ) state_in = ST_MEM_RD;
                  else state_in = ST_RESP;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_LOOKUP: begin
            priority if (op_ff == OP_WRITE) state_in = ST_RESP;
            else if (tag_stat.hit) state_in = ST_DATA_RD;
            else state_in = ST_FILL;
         end
         ST_DATA_RD: state_in = ST_RESP;
         ST_MEM_RD: state_in = ST_RESP;
         ST_FILL: begin
            if (fill_idx_ff == FILL_LAST) begin
               state_in = ST_FILL_END;
            end
         end
         ST_FILL_END: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs to the handshake, tag store and rams
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_addr = addr_ff;
      tag_cmd.two_way = (cache_mode == MODE_TWO_WAY);
      tag_cmd.inval = (state_ff == ST_DECODE) && (op_ff == OP_INVAL);
      tag_cmd.alloc = (state_ff == ST_LOOKUP) && (op_ff == OP_READ) && !tag_stat.hit;
      tag_cmd.touch = (state_ff == ST_LOOKUP) && (op_ff == OP_READ);
      bk_rd_addr = (state_ff == ST_FILL) ? fill_addr[MEM_AW-1:0] : addr_ff[MEM_AW-1:0];
      bk_we = 1'b0;
      bk_wr_addr = addr_ff[MEM_AW-1:0];
      bk_wr_data = wdata_ff;
      dt_rd_addr = data_addr(cur_line, off);
      dt_we = 1'b0;
      dt_wr_addr = data_addr(cur_line, off);
      dt_wr_data = wdata_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            bk_we = 1'b1;
            bk_wr_addr = clr_idx_ff;
            bk_wr_data = '0;
         end
         ST_DECODE: begin
            bk_we = (op_ff == OP_WRITE) && !range_bad && !cache_on;
         end
         ST_LOOKUP: begin
            bk_we = (op_ff == OP_WRITE);
            dt_we = (op_ff == OP_WRITE) && tag_stat.hit;
         end
         ST_FILL, ST_FILL_END: begin
            dt_we = pipe_vld_ff;
            dt_wr_addr = data_addr(line_ff, pipe_idx_ff);
            dt_wr_data = fill_word;
         end
         default: begin
         end
      endcase
   end

   // datapath register next values
   always_comb begin
      op_in = op_ff;
      addr_in = addr_ff;
      wdata_in = wdata_ff;
      res_data_in = res_data_ff;
      res_hit_in = res_hit_ff;
      res_err_in = res_err_ff;
      line_in = line_ff;
      fill_idx_in = fill_idx_ff;
      pipe_vld_in = pipe_vld_ff;
      pipe_idx_in = pipe_idx_ff;
      pipe_zero_in = pipe_zero_ff;
      clr_idx_in = clr_idx_ff;
      clr_rsp_in = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_err_in = rsp_err_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in = op_type'(req_tuser);
               addr_in = req_tdata[ADDR_W-1:0];
               wdata_in = req_tdata[2*WORD_W-1:WORD_W];
               res_data_in = '0;
               res_hit_in = 1'b0;
               res_err_in = 1'b0;
               fill_idx_in = '0;
               pipe_vld_in = 1'b0;
            end
         end
         ST_DECODE: begin
            if (op_ff == OP_CLEAR) begin
               clr_idx_in = '0;
               clr_rsp_in = 1'b1;
            end
            res_err_in = is_rw && range_bad;
         end
         ST_LOOKUP: begin
            res_hit_in = tag_stat.hit;
            line_in = cur_line;
         end
         ST_DATA_RD: res_data_in = dt_rd_data;
         ST_MEM_RD: res_data_in = bk_rd_data;
         ST_FILL, ST_FILL_END: begin
            fill_idx_in = fill_idx_ff + 1'b1;
            pipe_vld_in = (state_ff == ST_FILL);
            pipe_idx_in = fill_idx_ff;
            pipe_zero_in = fill_addr >= MEM_LIMIT;
            if (pipe_vld_ff && (pipe_idx_ff == off)) begin
               res_data_in = fill_word;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_data_ff;
               rsp_hit_in = res_hit_ff;
               rsp_err_in = res_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_idx_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      addr_ff <= addr_in;
      wdata_ff <= wdata_in;
      res_data_ff <= res_data_in;
      res_hit_ff <= res_hit_in;
      res_err_ff <= res_err_in;
      line_ff <= line_in;
      fill_idx_ff <= fill_idx_in;
      pipe_vld_ff <= pipe_vld_in;
      pipe_idx_ff <= pipe_idx_in;
      pipe_zero_ff <= pipe_zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = {rsp_err_ff, rsp_hit_ff};

endmodule

### rtl/write_through_set_assoc_cache.sv
// top level: write-through cache (bypass, direct mapped or two-way lru) over a word memory
// depends on wtsac_pkg, wtsac_ram, wtsac_tag_store and wtsac_ctrl
//
// channel  dir  handshake              word contents
// req_     in   req_tvalid/req_tready   tdata: address, write_data; tuser: op
// rsp_     out  rsp_tvalid/rsp_tready   tdata: read_data; tuser: hit, range_error
// csr_     in   csr_valid/csr_ready     data: cache_mode (write invalidates the cache)
//
// one word in flight at a time; a read miss fills its line by reading the backing ram
// one word a cycle through its single read port; the last word is written in ST_FILL_END
// reset starts a clearing pass over every word of the backing ram, with req_tready
// low; a clear-memory word runs the same pass before its response
// the response sits in an output register, so the next word is taken while it waits;
// a new result stalls only when that register is still full
// TOTAL_LINES and WORDS_PER_LINE are powers of two
module write_through_set_assoc_cache import wtsac_pkg::*; #(
   parameter int MEM_WORDS      = DEF_MEM_WORDS,
   parameter int TOTAL_LINES    = DEF_TOTAL_LINES,
   parameter int WORDS_PER_LINE = DEF_WORDS_PER_LINE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*WORD_W-1:0] req_tdata,   // address [15:0], write_data [31:16]
   input  logic [1:0]          req_tuser,   // op [1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,   // read_data [15:0]
   output logic [1:0]          rsp_tuser,   // hit [0], range_error [1]
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_data     // cache_mode [1:0]
);

   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int LINE_W = $clog2(TOTAL_LINES);
   localparam int DATA_AW = $clog2(TOTAL_LINES * WORDS_PER_LINE);

   logic [1:0] mode_ff, mode_in;
   logic csr_write;

   logic [ADDR_W-1:0] req_addr;
   tag_cmd_type ctrl_tag_cmd;
   tag_cmd_type tag_cmd;
   tag_stat_type tag_stat;
   logic [LINE_W-1:0] cur_line;

   logic [MEM_AW-1:0] bk_rd_addr;
   logic [WORD_W-1:0] bk_rd_data;
   logic bk_we;
   logic [MEM_AW-1:0] bk_wr_addr;
   logic [WORD_W-1:0] bk_wr_data;

   logic [DATA_AW-1:0] dt_rd_addr;
   logic [WORD_W-1:0] dt_rd_data;
   logic dt_we;
   logic [DATA_AW-1:0] dt_wr_addr;
   logic [WORD_W-1:0] dt_wr_data;

   // mode register, always ready; any write also drops every line
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      mode_in = csr_write ? csr_data : mode_ff;
      tag_cmd = ctrl_tag_cmd;
      tag_cmd.inval = ctrl_tag_cmd.inval || csr_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIRECT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   wtsac_ctrl #(
      .MEM_WORDS      (MEM_WORDS),
      .TOTAL_LINES    (TOTAL_LINES),
      .WORDS_PER_LINE (WORDS_PER_LINE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cache_mode (mode_ff),
      .req_addr   (req_addr),
      .tag_cmd    (ctrl_tag_cmd),
      .tag_stat   (tag_stat),
      .cur_line   (cur_line),
      .bk_rd_addr (bk_rd_addr),
      .bk_rd_data (bk_rd_data),
      .bk_we      (bk_we),
      .bk_wr_addr (bk_wr_addr),
      .bk_wr_data (bk_wr_data),
      .dt_rd_addr (dt_rd_addr),
      .dt_rd_data (dt_rd_data),
      .dt_we      (dt_we),
      .dt_wr_addr (dt_wr_addr),
      .dt_wr_data (dt_wr_data)
   );

   // tags, valid and lru bits
   wtsac_tag_store #(
      .TOTAL_LINES    (TOTAL_LINES),
      .WORDS_PER_LINE (WORDS_PER_LINE)
   ) u_tag_store (
      .clock (clock),
      .reset (reset),
      .addr  (req_addr),
      .cmd   (tag_cmd),
      .stat  (tag_stat),
      .line  (cur_line)
   );

   // cached line words, indexed by line and word offset
   wtsac_ram #(.DEPTH(TOTAL_LINES * WORDS_PER_LINE), .WIDTH(WORD_W)) u_data_ram (
      .clock   (clock),
      .we      (dt_we),
      .wr_addr (dt_wr_addr),
      .wr_data (dt_wr_data),
      .rd_addr (dt_rd_addr),
      .rd_data (dt_rd_data)
   );

   // backing memory
   wtsac_ram #(.DEPTH(MEM_WORDS), .WIDTH(WORD_W)) u_backing_ram (
      .clock   (clock),
      .we      (bk_we),
      .wr_addr (bk_wr_addr),
      .wr_data (bk_wr_data),
      .rd_addr (bk_rd_addr),
      .rd_data (bk_rd_data)
   );

endmodule

### test/testbench.sv
// self-checking bench for write_through_set_assoc_cache: random and directed words on the
// request stream, results checked against a shadow copy of memory, lines, tags and lru bits
// depends on wtsac_pkg and the rtl of the block, nothing else
`timescale 1ns / 1ps

module testbench import wtsac_pkg::*;;

   localparam int MEM_WORDS      = DEF_MEM_WORDS;
   localparam int TOTAL_LINES    = DEF_TOTAL_LINES;
   localparam int WORDS_PER_LINE = DEF_WORDS_PER_LINE;

   // unused mode code, the block treats it as bypass
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // no handshake anywhere for this long means the block is stuck; the clearing pass
   // after reset and after a clear-memory word is the longest legal quiet spell
   localparam int QUIET_LIMIT  = 5 * DEF_MEM_WORDS;
   localparam int PHASES       = 7;
   localparam int PHASE_WORDS  = 220;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_EVERY   = 600;

   typedef struct {
      op_type      op;
      logic [15:0] addr;
      logic [15:0] wdata;
      int unsigned gap;         // idle cycles before this word is offered
      bit          after_drain; // hold this word back until every result is in
   } req_item_type;

   typedef struct packed {
      logic [15:0] data;
      logic        hit;
      logic        range_error;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // address [15:0], write_data [31:16]
   logic [1:0]  req_tuser  = '0;   // op [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // read_data [15:0]
   logic [1:0]  rsp_tuser;         // hit [0], range_error [1]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data   = '0;   // cache_mode [1:0]

   // shadow state of the block
   logic [1:0]  shadow_mode;
   logic [15:0] shadow_mem   [0:MEM_WORDS-1];
   logic        shadow_valid [0:TOTAL_LINES-1];
   int          shadow_tag   [0:TOTAL_LINES-1];
   logic [15:0] shadow_data  [0:TOTAL_LINES*WORDS_PER_LINE-1];
   logic        shadow_lru   [0:TOTAL_LINES-1];

   req_item_type req_queue[$];          // words still to be offered
   outcome_type  awaited_results[$];    // results owed by the block, oldest first

   int unsigned req_count = 0;   // words accepted on the request side
   int unsigned rsp_count = 0;   // words accepted on the response side
   int unsigned failures  = 0;
   int unsigned hits_seen = 0;
   int unsigned errs_seen = 0;
   int unsigned req_gap   = 0;
   int unsigned rsp_wait  = 0;
   bit          rsp_eager = 1'b0;
   int unsigned rsp_hold  = 0;
   int unsigned next_hold_at = 300;
   int unsigned quiet_cycles = 0;

   write_through_set_assoc_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // invalidate drops valid bits, tags and data but leaves the lru bits alone
   function automatic void wipe_lines();
      for (int i = 0; i < TOTAL_LINES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_tag[i]   = 0;
      end
      for (int i = 0; i < TOTAL_LINES * WORDS_PER_LINE; i++)
         shadow_data[i] = '0;
   endfunction

   // applies one word to the shadow state and returns the result it must give
   function automatic outcome_type model_access(op_type op, logic [15:0] addr,
                                                logic [15:0] wdata);
      outcome_type res;
      int ways, sets, off, set_no, tag, base, found, way, ln, start, a;
      res = '0;
      a = addr;
      if (op == OP_INVAL) begin
         wipe_lines();
      end else if (op == OP_CLEAR) begin
         // backing store only, valid lines keep their stale data
         for (int i = 0; i < MEM_WORDS; i++)
            shadow_mem[i] = '0;
      end else if (a >= MEM_WORDS) begin
         res.range_error = 1'b1;
      end else if (shadow_mode != MODE_DIRECT && shadow_mode != MODE_TWO_WAY) begin
         if (op == OP_READ)
            res.data = shadow_mem[a];
         else
            shadow_mem[a] = wdata;
      end else begin
         ways   = (shadow_mode == MODE_TWO_WAY) ? 2 : 1;
         sets   = TOTAL_LINES / ways;
         off    = a % WORDS_PER_LINE;
         set_no = (a / WORDS_PER_LINE) % sets;
         tag    = a / (WORDS_PER_LINE * sets);
         base   = set_no * ways;
         found  = -1;
         for (int w = 0; w < ways; w++) begin
            if (found < 0 && shadow_valid[base + w] && shadow_tag[base + w] == tag)
               found = w;
         end
         if (op == OP_WRITE) begin
            // write-through, no allocate on a miss
            if (found >= 0) begin
               shadow_data[(base + found) * WORDS_PER_LINE + off] = wdata;
               res.hit = 1'b1;
            end
            shadow_mem[a] = wdata;
         end else begin
            if (found >= 0) begin
               way = found;
               res.hit = 1'b1;
            end else begin
               // victim is way 0 when its lru bit is set, else way 1
               if (ways == 2)
                  way = shadow_lru[base] ? 0 : 1;
               else
                  way = 0;
               ln = base + way;
               start = a - off;
               shadow_tag[ln]   = tag;
               shadow_valid[ln] = 1'b1;
               for (int i = 0; i < WORDS_PER_LINE; i++)
                  shadow_data[ln * WORDS_PER_LINE + i] =
                     (start + i < MEM_WORDS) ? shadow_mem[start + i] : 16'h0000;
            end
            ln = base + way;
            if (ways == 2) begin
               shadow_lru[base + way]     = 1'b0;
               shadow_lru[base + 1 - way] = 1'b1;
            end
            res.data = shadow_data[ln * WORDS_PER_LINE + off];
         end
      end
      return res;
   endfunction

   function automatic void queue_word(op_type op, logic [15:0] addr, logic [15:0] wdata,
                                      int unsigned gap, bit after_drain);
      req_item_type it;
      it.op          = op;
      it.addr        = addr;
      it.wdata       = wdata;
      it.gap         = gap;
      it.after_drain = after_drain;
      req_queue.push_back(it);
   endfunction

   // request driver: predicts each word at the edge it is taken, then offers the next one
   // after its gap; tvalid gets a single assignment per edge so back-to-back words stay high
   always @(posedge clock) begin : driver
      logic         offering;
      int unsigned  taken;
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         offering = req_tvalid;
         taken    = req_count;
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(model_access(op_type'(req_tuser), req_tdata[15:0],
                                                   req_tdata[31:16]));
            taken = taken + 1;
            req_count <= taken;
            offering = 1'b0;
         end
         if (!offering && req_queue.size() > 0) begin
            if (req_gap < req_queue[0].gap) begin
               req_gap = req_gap + 1;
            end else if (!req_queue[0].after_drain || taken == rsp_count) begin
               nxt = req_queue.pop_front();
               req_tdata <= {nxt.wdata, nxt.addr};
               req_tuser <= nxt.op;
               req_gap = 0;
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
      end
   end

   // every HOLD_EVERY words the receiver goes quiet for a long spell while the sender keeps
   // pushing, so the output register fills and the block has to stall its input
   always @(posedge clock) begin : receiver_hold
      if (reset) begin
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (req_count >= next_hold_at) begin
         rsp_hold     <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_EVERY;
      end
   end

   // response monitor: checks each result against the oldest owed one, then draws its stall
   always @(posedge clock) begin : monitor
      outcome_type want;
      outcome_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            got.data        = rsp_tdata;
            got.hit         = rsp_tuser[0];
            got.range_error = rsp_tuser[1];
            hits_seen = hits_seen + got.hit;
            errs_seen = errs_seen + got.range_error;
            if (awaited_results.size() == 0) begin
               failures = failures + 1;
               if (failures <= 10)
                  $display("%0t: result with none owed: data %h hit %b range_error %b",
                           $realtime, got.data, got.hit, got.range_error);
            end else begin
               want = awaited_results.pop_front();
               if (got.data !== want.data || got.hit !== want.hit ||
                   got.range_error !== want.range_error) begin
                  failures = failures + 1;
                  if (failures <= 10)
                     $display({"%0t: mismatch, expected data %h hit %b range_error %b,",
                               " got data %h hit %b range_error %b"},
                              $realtime, want.data, want.hit, want.range_error,
                              got.data, got.hit, got.range_error);
               end
            end
            rsp_wait = rsp_eager ? 0 : $urandom_range(0, 4);
            // now and then switch between stalling and taking every word at once
            if ($urandom_range(0, 59) == 0)
               rsp_eager = !rsp_eager;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_tready <= (rsp_wait == 0) && (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no word moved for %0d cycles, %0d results still owed",
                  QUIET_LIMIT, awaited_results.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // waits at falling edges, away from the clocked processes, until all is settled
   task automatic wait_drained();
      do @(negedge clock);
      while (req_queue.size() != 0 || req_tvalid || req_count != rsp_count ||
             awaited_results.size() != 0);
   endtask

   // mode writes happen only with the block idle; any write invalidates the cache
   task automatic write_mode(input logic [1:0] mode);
      @(posedge clock);
      csr_data  <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      shadow_mode = mode;
      wipe_lines();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [1:0]  mode;
      logic [15:0] hot_base;
      logic [15:0] addr;
      logic [15:0] wdata;
      op_type      op;
      bit          burst;
      int          r;
      int          clears_left;

      shadow_mode = MODE_DIRECT;
      for (int i = 0; i < MEM_WORDS; i++)
         shadow_mem[i] = '0;
      for (int i = 0; i < TOTAL_LINES; i++)
         shadow_lru[i] = 1'b0;
      wipe_lines();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words in the reset mode (direct mapped)
      queue_word(OP_READ,  16'h0000, 16'h0000, 0, 0);   // cold miss, zeros
      queue_word(OP_WRITE, 16'h0000, 16'hFFFF, 0, 0);   // write hit on the fresh line
      queue_word(OP_READ,  16'h0000, 16'h0000, 1, 0);   // read hit sees the write
      queue_word(OP_WRITE, 16'h0005, 16'h1234, 0, 0);   // write miss, no allocate
      queue_word(OP_READ,  16'h0005, 16'h0000, 0, 0);   // miss fills from memory
      queue_word(OP_READ,  16'h7FFF, 16'h0000, 2, 0);   // last word in range
      queue_word(OP_WRITE, 16'h7FFF, 16'hA5A5, 0, 0);
      queue_word(OP_READ,  16'h8000, 16'h0000, 0, 0);   // first word out of range
      queue_word(OP_WRITE, 16'hFFFF, 16'hFFFF, 0, 0);   // ignored, flagged
      queue_word(OP_READ,  16'hFFFF, 16'h5A5A, 3, 0);
      queue_word(OP_CLEAR, 16'h1357, 16'hFFFF, 0, 1);
      queue_word(OP_READ,  16'h0000, 16'h0000, 0, 0);   // stale line still hits after clear
      queue_word(OP_READ,  16'h7FFF, 16'h0000, 0, 0);
      queue_word(OP_INVAL, 16'hFFFF, 16'h0000, 0, 0);
      queue_word(OP_READ,  16'h0000, 16'h0000, 4, 0);   // miss, memory now zero
      queue_word(OP_WRITE, 16'h0040, 16'h8001, 0, 0);   // same set as address 0
      queue_word(OP_READ,  16'h0040, 16'h0000, 0, 0);   // evicts the line of address 0
      queue_word(OP_READ,  16'h0000, 16'h0000, 0, 0);
      queue_word(OP_READ,  16'h0041, 16'h0000, 0, 0);
      wait_drained();

      clears_left = 5;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0, 3, 6: mode = MODE_TWO_WAY;
            1, 5:    mode = MODE_DIRECT;
            2:       mode = MODE_BYPASS;
            default: mode = MODE_SPARE;
         endcase
         write_mode(mode);
         hot_base = 16'($urandom_range(0, 127) * 256);
         burst = 1'b0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0)
               burst = ($urandom_range(0, 3) == 0);
            if (n % 64 == 63)
               hot_base = 16'($urandom_range(0, 127) * 256);

            // mostly reads and writes around a small window so lines get reused
            r = $urandom_range(0, 99);
            if (r < 55)
               op = OP_READ;
            else if (r < 97)
               op = OP_WRITE;
            else
               op = OP_INVAL;
            if (clears_left > 0 && $urandom_range(0, 249) == 0) begin
               op = OP_CLEAR;
               clears_left = clears_left - 1;
            end

            r = $urandom_range(0, 99);
            if (r < 55)
               addr = hot_base + 16'($urandom_range(0, 255));
            else if (r < 70)   // same set over several tags, works the victim choice
               addr = hot_base + 16'($urandom_range(0, 7) * 32 + $urandom_range(0, 3));
            else if (r < 85)
               addr = 16'($urandom_range(0, 65535));
            else if (r < 95)   // around the end of memory
               addr = 16'($urandom_range(32760, 32775));
            else if (r < 98)
               addr = 16'($urandom_range(0, 7));
            else
               addr = 16'($urandom_range(65528, 65535));

            r = $urandom_range(0, 9);
            if (r == 0)
               wdata = 16'hFFFF;
            else if (r == 1)
               wdata = 16'h0000;
            else
               wdata = 16'($urandom_range(0, 65535));

            queue_word(op, addr, wdata, burst ? 0 : $urandom_range(0, 4),
                       (n == 100) || ($urandom_range(0, 119) == 0));
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("%0d words checked over bypass, spare, direct and two-way modes", rsp_count);
      $display("%0d cache hits, %0d range errors, %0d failures", hits_seen, errs_seen, failures);
      if (failures == 0 && awaited_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
